>>> rtl/core/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared constants, codes and controller/datapath interface types for the
// indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    // Store geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int ECNT_W   = 7;

    // Width used to compare a position against the count
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Stream payload widths
    localparam int S_DATA_W = 40;   // position, item_value, zero fill
    localparam int M_DATA_W = 40;   // read_value, element_count, zero fill

    // Request codes
    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
    localparam logic [OP_W-1:0] OP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ_WAIT,
        S_INS_CHK,
        S_INS_WR,
        S_DEL_CHK,
        S_DEL_WR,
        S_RESULT
    } state_t;

    // Element memory read address select
    typedef enum logic [1:0] {
        RD_POS,     // requested position
        RD_BELOW,   // k - 1, insert shift
        RD_ABOVE    // k + 1, delete shift
    } rd_sel_t;

    // Shift loop setup
    typedef enum logic {
        INIT_INSERT,
        INIT_DELETE
    } init_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic              capture;     // latch request
        logic              rd_en;
        rd_sel_t           rd_sel;
        logic              wr_move;     // mem[k] <= read data
        logic              wr_value;    // mem[k] <= item value
        logic              loop_init;
        init_sel_t         init_sel;
        logic              k_inc;
        logic              k_dec;
        logic              count_inc;
        logic              count_dec;
        logic              res_set;
        logic [STAT_W-1:0] res_status;
        logic              res_from_mem;
        logic              out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] req_op;
        logic            pos_lt_count;
        logic            pos_le_count;
        logic            full;
        logic            k_at_tgt;
        logic            out_free;
    } stat_t;

endpackage

>>> rtl/core/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of signed 32-bit values with indexed read, insert and
// delete, one result transaction per request transaction.
// ----------------------------------------------------------------------------
// The list lives in a single-port-style element memory (one write and one
// registered read per cycle) of CAPACITY entries, so every element that has
// to move is first read and then written back one place over. A request
// goes from acceptance through decode to its result: a rejected or unused
// request goes there at once, a read through a read wait, an insert at
// effective position p (0 for front, count for append) through a loop that
// moves count - p elements up, and a delete at p through one that moves
// count - 1 - p down. The result then waits for the output register to free.
// One request is worked on at a time; s_tready is high only between
// requests, but a finished result may still sit in the output register
// while the next request is accepted. Out-of-range positions give status 1
// and leave the list alone; an insert into a full store gives status 2 and
// is dropped (the range check wins when both apply). read_value is zero on
// anything but a successful read, and element_count is the count after the
// request.
// ----------------------------------------------------------------------------
module indexed_list_engine
    import ile_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // request channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [6:0] position, [38:7] item_value, [39] zero
    input  logic [OP_W-1:0]     s_tuser,   // [2:0] op
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [31:0] read_value, [38:32] element_count, [39] zero
    output logic [STAT_W-1:0]   m_tuser    // [1:0] status
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: decode, checks, shift loops
    ile_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // element memory, count and result registers
    ile_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_op     (s_tuser),
        .s_pos    (s_tdata[POS_W-1:0]),
        .s_val    (s_tdata[POS_W+VAL_W-1:POS_W]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/core/ile_datapath.sv
// ----------------------------------------------------------------------------
// ile_datapath
// Element memory, count, shift index and result registers.
// ----------------------------------------------------------------------------
module ile_datapath
    import ile_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [OP_W-1:0]     s_op,
    input  logic [POS_W-1:0]    s_pos,
    input  logic [VAL_W-1:0]    s_val,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [STAT_W-1:0]   m_tuser
);

    logic [VAL_W-1:0]  mem [CAPACITY];

    logic [OP_W-1:0]   op_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  tgt_reg;
    logic [VAL_W-1:0]  rdata_reg;
    logic [VAL_W-1:0]  res_value_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_value_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [ECNT_W-1:0] m_count_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  ins_tgt;
    logic [CMP_W-1:0]  pos_cmp;
    logic [CMP_W-1:0]  count_cmp;

    assign pos_cmp   = CMP_W'(pos_reg);
    assign count_cmp = CMP_W'(count_reg);

    assign stat.req_op       = op_reg;
    assign stat.pos_lt_count = pos_cmp < count_cmp;
    assign stat.pos_le_count = pos_cmp <= count_cmp;
    assign stat.full         = count_reg == CNT_W'(CAPACITY);
    assign stat.k_at_tgt     = k_reg == tgt_reg;
    assign stat.out_free     = !m_valid_reg || m_tready;

    always_comb begin
        case (cmd.rd_sel)
            RD_BELOW: rd_addr = ADDR_W'(k_reg - CNT_W'(1));
            RD_ABOVE: rd_addr = ADDR_W'(k_reg + CNT_W'(1));
            default:  rd_addr = ADDR_W'(pos_reg);
        endcase
    end

    assign wr_addr = ADDR_W'(k_reg);

    always_comb begin
        if (op_reg == OP_FRONT) begin
            ins_tgt = '0;
        end else if (op_reg == OP_BACK) begin
            ins_tgt = count_reg;
        end else begin
            ins_tgt = CNT_W'(pos_reg);
        end
    end

    // element memory: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_move) begin
            mem[wr_addr] <= rdata_reg;
        end else if (cmd.wr_value) begin
            mem[wr_addr] <= val_reg;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // request, shift index and pending result
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_op;
            pos_reg <= s_pos;
            val_reg <= s_val;
        end
        if (cmd.loop_init) begin
            if (cmd.init_sel == INIT_DELETE) begin
                k_reg   <= CNT_W'(pos_reg);
                tgt_reg <= count_reg - CNT_W'(1);
            end else begin
                k_reg   <= count_reg;
                tgt_reg <= ins_tgt;
            end
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + CNT_W'(1);
        end else if (cmd.k_dec) begin
            k_reg <= k_reg - CNT_W'(1);
        end
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_from_mem ? rdata_reg : '0;
        end
        if (cmd.out_load) begin
            m_value_reg  <= res_value_reg;
            m_status_reg <= res_status_reg;
            m_count_reg  <= ECNT_W'(count_reg);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.count_inc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.count_dec) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - VAL_W - ECNT_W){1'b0}}, m_count_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

endmodule

>>> rtl/core/ile_ctrl.sv
// ----------------------------------------------------------------------------
// ile_ctrl
// Request sequencer: decode, range/full checks, element shift loops and
// result hand-off.
// ----------------------------------------------------------------------------
module ile_ctrl
    import ile_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.req_op) inside
                    OP_READ: begin
                        state_next = stat.pos_lt_count ? S_READ_WAIT : S_RESULT;
                    end
                    OP_FRONT, OP_BACK, OP_INSERT: begin
                        if ((stat.req_op == OP_INSERT && !stat.pos_le_count) || stat.full) begin
                            state_next = S_RESULT;
                        end else begin
                            state_next = S_INS_CHK;
                        end
                    end
                    OP_DELETE: begin
                        state_next = stat.pos_lt_count ? S_DEL_CHK : S_RESULT;
                    end
                    default: state_next = S_RESULT;
                endcase
            end
            S_READ_WAIT: state_next = S_RESULT;
            S_INS_CHK:   state_next = stat.k_at_tgt ? S_RESULT : S_INS_WR;
            S_INS_WR:    state_next = S_INS_CHK;
            S_DEL_CHK:   state_next = stat.k_at_tgt ? S_RESULT : S_DEL_WR;
            S_DEL_WR:    state_next = S_DEL_CHK;
            S_RESULT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DECODE: begin
                case (stat.req_op) inside
                    OP_READ: begin
                        if (stat.pos_lt_count) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_POS;
                        end else begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = STAT_RANGE;
                        end
                    end
                    OP_FRONT, OP_BACK, OP_INSERT: begin
                        if (stat.req_op == OP_INSERT && !stat.pos_le_count) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = STAT_RANGE;
                        end else if (stat.full) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = STAT_FULL;
                        end else begin
                            cmd.loop_init = 1'b1;
                            cmd.init_sel  = INIT_INSERT;
                        end
                    end
                    OP_DELETE: begin
                        if (stat.pos_lt_count) begin
                            cmd.loop_init = 1'b1;
                            cmd.init_sel  = INIT_DELETE;
                        end else begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = STAT_RANGE;
                        end
                    end
                    default: begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = STAT_DONE;
                    end
                endcase
            end
            S_READ_WAIT: begin
                cmd.res_set      = 1'b1;
                cmd.res_status   = STAT_DONE;
                cmd.res_from_mem = 1'b1;
            end
            S_INS_CHK: begin
                if (stat.k_at_tgt) begin
                    cmd.wr_value   = 1'b1;
                    cmd.count_inc  = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_BELOW;
                end
            end
            S_INS_WR: begin
                cmd.wr_move = 1'b1;
                cmd.k_dec   = 1'b1;
            end
            S_DEL_CHK: begin
                if (stat.k_at_tgt) begin
                    cmd.count_dec  = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ABOVE;
                end
            end
            S_DEL_WR: begin
                cmd.wr_move = 1'b1;
                cmd.k_inc   = 1'b1;
            end
            S_RESULT: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for indexed_list_engine. A short table of directed
// requests covers the empty list, the value extremes, every request code,
// range rejections and the unused codes. It is followed by random traffic
// that swings the list between empty and full, so full-store drops are hit
// many times. Every result transaction is checked against a behavioral
// copy of the list. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    // Request codes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // Random traffic phases
    localparam int PH_GROW   = 0;   // mostly inserts, runs until the store is full
    localparam int PH_SHRINK = 1;   // mostly deletes, runs until the store is empty
    localparam int PH_MIX    = 2;   // balanced, fixed length

    localparam int RANDOM_ITEMS = 1680;
    localparam int MIX_LEN      = 150;
    localparam int MAX_GAP      = 17;
    localparam int IDLE_LIMIT   = 2000;  // above the slowest request plus two gaps
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [STAT_W-1:0] status;
        logic [ECNT_W-1:0] element_count;
    } list_result_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             typed;    // 1: use the result typed below
        list_result_t     want;
    } stim_row_t;

    localparam int N_ROWS = 25;

    // Typed results are the ones obvious from the list contents at that point.
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // empty list: everything indexed is out of range
        '{OP_READ,    7'd0,   32'h0000_0000, 1'b1, '{32'h0, STAT_RANGE, 7'd0}},
        '{OP_DELETE,  7'd0,   32'h0000_0000, 1'b1, '{32'h0, STAT_RANGE, 7'd0}},
        '{OP_INSERT,  7'd1,   32'h0000_0005, 1'b1, '{32'h0, STAT_RANGE, 7'd0}},
        // insert at position equal to count, then the value extremes
        '{OP_INSERT,  7'd0,   32'h8000_0000, 1'b1, '{32'h0, STAT_DONE,  7'd1}},
        '{OP_BACK,    7'd127, 32'h7FFF_FFFF, 1'b1, '{32'h0, STAT_DONE,  7'd2}},
        '{OP_FRONT,   7'd0,   32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_DONE,  7'd3}},
        '{OP_READ,    7'd0,   32'h1234_5678, 1'b1, '{32'hFFFF_FFFF, STAT_DONE, 7'd3}},
        '{OP_READ,    7'd2,   32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, STAT_DONE, 7'd3}},
        '{OP_READ,    7'd3,   32'h0000_0000, 1'b1, '{32'h0, STAT_RANGE, 7'd3}},
        '{OP_READ,    7'd127, 32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_RANGE, 7'd3}},
        '{OP_INSERT,  7'd3,   32'h0000_0000, 1'b1, '{32'h0, STAT_DONE,  7'd4}},
        '{OP_INSERT,  7'd5,   32'h0000_0001, 1'b1, '{32'h0, STAT_RANGE, 7'd4}},
        '{OP_INSERT,  7'd127, 32'hA5A5_A5A5, 1'b1, '{32'h0, STAT_RANGE, 7'd4}},
        // mid-list insert and the reads around it
        '{OP_INSERT,  7'd1,   32'h1234_5678, 1'b0, '0},
        '{OP_READ,    7'd1,   32'h0000_0000, 1'b0, '0},
        '{OP_READ,    7'd2,   32'h0000_0000, 1'b0, '0},
        // unused codes leave the list alone
        '{OP_SPARE_5, 7'd127, 32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_DONE,  7'd5}},
        '{OP_SPARE_6, 7'd0,   32'h8000_0000, 1'b1, '{32'h0, STAT_DONE,  7'd5}},
        '{OP_SPARE_7, 7'd85,  32'h5A5A_5A5A, 1'b1, '{32'h0, STAT_DONE,  7'd5}},
        // deletes: out of range, last element, first element
        '{OP_DELETE,  7'd127, 32'h0000_0000, 1'b1, '{32'h0, STAT_RANGE, 7'd5}},
        '{OP_DELETE,  7'd5,   32'h0000_0000, 1'b1, '{32'h0, STAT_RANGE, 7'd5}},
        '{OP_DELETE,  7'd4,   32'h0000_0000, 1'b0, '0},
        '{OP_DELETE,  7'd0,   32'h0000_0000, 1'b0, '0},
        '{OP_READ,    7'd0,   32'h0000_0000, 1'b0, '0},
        '{OP_BACK,    7'd0,   32'h0000_0001, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // [6:0] position, [38:7] item_value, [39] zero
    logic [OP_W-1:0]     s_tuser  = '0;   // [2:0] op
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [31:0] read_value, [38:32] element_count, [39] zero
    logic [STAT_W-1:0]   m_tuser;         // [1:0] status

    indexed_list_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Behavioral list: its own store and count, stepped once per accepted
    // request transaction, in acceptance order.
    // ------------------------------------------------------------------------
    logic [VAL_W-1:0] list_mem [CAPACITY];
    int               list_count = 0;

    list_result_t     awaited_results [$];
    int               errors = 0;
    bit               tx_calm = 1'b0;   // stretches with no sender gaps
    bit               rx_calm = 1'b0;   // stretches with no receiver stalls

    function automatic list_result_t apply_request(input logic [OP_W-1:0]  op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [VAL_W-1:0] val);
        list_result_t r;
        int           where;
        r     = '0;
        where = -1;     // no insert pending
        case (op)
            OP_READ: begin
                if (pos < list_count) r.read_value = list_mem[pos[ADDR_W-1:0]];
                else r.status = STAT_RANGE;
            end
            OP_FRONT: where = 0;
            OP_BACK:  where = list_count;
            OP_INSERT: begin
                // range is checked ahead of the full check
                if (pos > list_count) r.status = STAT_RANGE;
                else where = int'(pos);
            end
            OP_DELETE: begin
                if (pos < list_count) begin
                    for (int k = int'(pos); k + 1 < list_count; k++)
                        list_mem[k] = list_mem[k + 1];
                    list_count--;
                end else begin
                    r.status = STAT_RANGE;
                end
            end
            default: ;  // unused codes: no change
        endcase
        if (where >= 0) begin
            if (list_count >= CAPACITY) begin
                r.status = STAT_FULL;
            end else begin
                for (int k = list_count; k > where; k--) list_mem[k] = list_mem[k - 1];
                list_mem[where] = val;
                list_count++;
            end
        end
        r.element_count = list_count[ECNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Driven with NBAs at the rising edge; tready is sampled
    // as it was before the edge. tvalid only drops when a gap follows, so it
    // gets a single NBA per time step.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [OP_W-1:0]  op,
                                input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val,
                                input logic             typed,
                                input list_result_t     want);
        int           gap;
        list_result_t got;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, pos};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        // transaction taken at this edge
        got = apply_request(op, pos, val);
        awaited_results.push_back(typed ? want : got);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, in-order check against the oldest
    // expectation.
    // ------------------------------------------------------------------------
    initial begin
        int           gap;
        list_result_t want;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result transaction rd=%h st=%0d cnt=%0d",
                         $realtime, m_tdata[31:0], m_tuser, m_tdata[38:32]);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata[31:0] !== want.read_value || m_tuser !== want.status ||
                    m_tdata[38:32] !== want.element_count) begin
                    $display("%0t: mismatch expected rd=%h st=%0d cnt=%0d actual rd=%h st=%0d cnt=%0d",
                             $realtime, want.read_value, want.status, want.element_count,
                             m_tdata[31:0], m_tuser, m_tdata[38:32]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too many cycles without any transaction on either channel
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int               roll;
        int               del_w;
        int               phase;
        int               phase_left;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;

        phase      = PH_GROW;
        phase_left = 0;

        // single reset
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].pos, DIRECTED_ROWS[i].val,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // Random part: grow to full (and bang on it), shrink to empty, then a
        // balanced stretch, over and over.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case (phase)
                PH_GROW: begin
                    if (list_count == CAPACITY && $urandom_range(0, 5) == 0) phase = PH_SHRINK;
                end
                PH_SHRINK: begin
                    if (list_count == 0 && $urandom_range(0, 5) == 0) begin
                        phase      = PH_MIX;
                        phase_left = MIX_LEN;
                    end
                end
                default: begin
                    if (phase_left == 0) phase = PH_GROW;
                    else phase_left--;
                end
            endcase
            del_w = (phase == PH_GROW) ? 12 : (phase == PH_SHRINK) ? 60 : 30;

            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                case ($urandom_range(0, 2))
                    0:       op = OP_SPARE_5;
                    1:       op = OP_SPARE_6;
                    default: op = OP_SPARE_7;
                endcase
            end else if (roll < 22) begin
                op = OP_READ;
            end else if (roll < 22 + del_w) begin
                op = OP_DELETE;
            end else begin
                case ($urandom_range(0, 2))
                    0:       op = OP_FRONT;
                    1:       op = OP_BACK;
                    default: op = OP_INSERT;
                endcase
            end

            // mostly legal positions, some anywhere in the 7-bit range
            if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 127));
            else if (op == OP_INSERT) pos = POS_W'($urandom_range(0, list_count));
            else pos = (list_count == 0) ? '0 : POS_W'($urandom_range(0, list_count - 1));

            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7FFF_FFFF;
                    2:       val = 32'hFFFF_FFFF;
                    default: val = 32'h0000_0000;
                endcase
            end else begin
                val = $urandom;
            end

            send_request(op, pos, val, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain, then let the slowest request's worth of cycles pass
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
